>>> rtl/assert_macros.svh
// Assertion macros used by the interval colouring RTL.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset
`define IGC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Implication checked in the same cycle
`define IGC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/igc_pkg.sv
// Package for the interval graph colouring block: sizes, payload words, command/status.
// No dependencies.
package igc_pkg;

    localparam int MAX_INTERVALS = 32;
    localparam int COORD_WIDTH   = 16;
    localparam int IDX_W         = $clog2(MAX_INTERVALS);
    localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
    localparam int COLOR_W       = 5;
    localparam int DEG_W         = 5;
    localparam int CHROM_W       = 6;
    localparam int EDGE_W        = 9;
    localparam int DSUM_W        = 11;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] start_point;
        logic signed [COORD_WIDTH-1:0] end_point;
        logic                          last_interval;
    } in_word_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] interval_start;
        logic signed [COORD_WIDTH-1:0] interval_stop;
        logic [COLOR_W-1:0]            assigned_color;
        logic [EDGE_W-1:0]             edge_total;
        logic [DEG_W-1:0]              max_degree;
        logic [DEG_W-1:0]              min_degree;
        logic [CHROM_W-1:0]            chromatic_number;
        logic [EDGE_W-1:0]             complement_edges;
        logic [DEG_W-1:0]              max_complement_degree;
        logic [DEG_W-1:0]              min_complement_degree;
        logic                          overflow;
        logic                          last_result;
    } out_word_t;

    // Controller to datapath
    typedef struct packed {
        logic             insert;
        logic             walk_start;
        logic             sel;
        logic             eval;
        logic             emit_item;
        logic             emit_sum;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             out_free;
    } status_t;

endpackage

>>> rtl/igc_datapath.sv
// Datapath: sorted interval cells, overlap/colour evaluation, output register.
// Depends on igc_pkg.
module igc_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  igc_pkg::cmd_t      cmd,
    output igc_pkg::status_t   status,
    input  igc_pkg::in_word_t  in_word,
    output igc_pkg::out_word_t out_word,
    output logic               out_valid,
    input  logic               out_ready
);
    import igc_pkg::*;

    logic signed [COORD_WIDTH-1:0] start_reg [MAX_INTERVALS];
    logic signed [COORD_WIDTH-1:0] stop_reg  [MAX_INTERVALS];
    logic [COLOR_W-1:0]            color_reg [MAX_INTERVALS];
    logic [DEG_W-1:0]              deg_reg   [MAX_INTERVALS];

    logic [CNT_W-1:0]              count_reg;
    logic                          ovf_reg;
    logic signed [COORD_WIDTH-1:0] cur_start_reg, cur_stop_reg;
    logic [COLOR_W-1:0]            maxc_reg;
    logic [DSUM_W-1:0]             dsum_reg;
    logic [DEG_W-1:0]              maxd_reg, mind_reg;
    out_word_t                     out_reg;
    logic                          out_valid_reg;

    logic [MAX_INTERVALS-1:0] gt, prev_gt, ov;
    logic [MAX_INTERVALS-1:0] busy;
    logic [COLOR_W-1:0]       free_color;
    logic                     full;
    logic [DEG_W-1:0]         emit_deg;
    logic [2*CNT_W-1:0]       pair_prod;
    logic [EDGE_W-1:0]        edges;
    out_word_t                sum_word, item_word;

    assign full = (count_reg == CNT_W'(MAX_INTERVALS));

    // Insertion compare in every cell
    always_comb begin
        for (int k = 0; k < MAX_INTERVALS; k++) begin
            gt[k] = (CNT_W'(k) < count_reg) && (start_reg[k] > in_word.start_point);
        end
        prev_gt[0] = 1'b0;
        for (int k = 1; k < MAX_INTERVALS; k++) begin
            prev_gt[k] = gt[k-1];
        end
    end

    // Overlap of every cell with the selected interval, and the busy colour set
    always_comb begin
        busy = '0;
        for (int j = 0; j < MAX_INTERVALS; j++) begin
            ov[j] = (CNT_W'(j) < count_reg) && (IDX_W'(j) != cmd.idx)
                    && (stop_reg[j] >= cur_start_reg) && (cur_stop_reg >= start_reg[j]);
            if (ov[j] && (IDX_W'(j) < cmd.idx)) begin
                busy[color_reg[j]] = 1'b1;
            end
        end
    end

    // Lowest free colour
    always_comb begin
        free_color = '0;
        for (int c = MAX_INTERVALS - 1; c >= 0; c--) begin
            if (!busy[c]) begin
                free_color = COLOR_W'(c);
            end
        end
    end

    assign emit_deg = deg_reg[cmd.idx];

    // Item and summary words
    always_comb begin
        item_word                = '0;
        item_word.interval_start = start_reg[cmd.idx];
        item_word.interval_stop  = stop_reg[cmd.idx];
        item_word.assigned_color = color_reg[cmd.idx];

        pair_prod = (2*CNT_W)'(count_reg) * (2*CNT_W)'(count_reg - 1'b1);
        edges     = EDGE_W'(dsum_reg >> 1);

        sum_word                       = '0;
        sum_word.edge_total            = edges;
        sum_word.max_degree            = maxd_reg;
        sum_word.min_degree            = mind_reg;
        sum_word.chromatic_number      = CHROM_W'(maxc_reg) + 1'b1;
        sum_word.complement_edges      = EDGE_W'(pair_prod >> 1) - edges;
        sum_word.max_complement_degree = DEG_W'(count_reg - 1'b1) - mind_reg;
        sum_word.min_complement_degree = DEG_W'(count_reg - 1'b1) - maxd_reg;
        sum_word.overflow              = ovf_reg;
        sum_word.last_result           = 1'b1;
    end

    // Interval cells
    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_INTERVALS; k++) begin
            if (cmd.insert && !full && ((CNT_W'(k) == count_reg) || gt[k])) begin
                if (prev_gt[k]) begin
                    start_reg[k] <= start_reg[(k + MAX_INTERVALS - 1) % MAX_INTERVALS];
                    stop_reg[k]  <= stop_reg[(k + MAX_INTERVALS - 1) % MAX_INTERVALS];
                end else begin
                    start_reg[k] <= in_word.start_point;
                    stop_reg[k]  <= in_word.end_point;
                end
            end
            if (cmd.walk_start) begin
                deg_reg[k] <= '0;
            end else if (cmd.eval && ov[k]) begin
                deg_reg[k] <= deg_reg[k] + 1'b1;
            end
        end
        if (cmd.eval) begin
            color_reg[cmd.idx] <= free_color;
        end
        if (cmd.sel) begin
            cur_start_reg <= start_reg[cmd.idx];
            cur_stop_reg  <= stop_reg[cmd.idx];
        end
    end

    // Run statistics and output word register
    always_ff @(posedge aclk) begin
        if (cmd.walk_start) begin
            maxc_reg <= '0;
            dsum_reg <= '0;
            maxd_reg <= '0;
            mind_reg <= '1;
        end else begin
            if (cmd.eval && (free_color > maxc_reg)) begin
                maxc_reg <= free_color;
            end
            if (cmd.emit_item) begin
                dsum_reg <= dsum_reg + DSUM_W'(emit_deg);
                if (emit_deg > maxd_reg) maxd_reg <= emit_deg;
                if (emit_deg < mind_reg) mind_reg <= emit_deg;
            end
        end
        if (cmd.emit_item) begin
            out_reg <= item_word;
        end else if (cmd.emit_sum) begin
            out_reg <= sum_word;
        end
    end

    // Control state: fill count, overflow, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.emit_sum) begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end else if (cmd.insert) begin
                if (full) ovf_reg <= 1'b1;
                else      count_reg <= count_reg + 1'b1;
            end
            if (cmd.emit_item || cmd.emit_sum) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.count    = count_reg;
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_word        = out_reg;
    assign out_valid       = out_valid_reg;

endmodule

>>> rtl/igc_ctrl.sv
// Controller: load, overlap walk, emission and summary sequencing.
// Depends on igc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module igc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic             in_last,
    output logic             in_ready,
    input  igc_pkg::status_t status,
    output igc_pkg::cmd_t    cmd
);
    import igc_pkg::*;

    typedef enum logic [2:0] {S_LOAD, S_SEL, S_EVAL, S_EMIT, S_SUM} state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             at_last;

    assign at_last  = ((CNT_W'(idx_reg) + 1'b1) == status.count);
    assign in_ready = (state_reg == S_LOAD);

    // Commands decoded from state
    always_comb begin
        cmd            = '0;
        cmd.idx        = idx_reg;
        cmd.insert     = in_ready && in_valid;
        cmd.walk_start = in_ready && in_valid && in_last;
        cmd.sel        = (state_reg == S_SEL);
        cmd.eval       = (state_reg == S_EVAL);
        cmd.emit_item  = (state_reg == S_EMIT) && status.out_free;
        cmd.emit_sum   = (state_reg == S_SUM) && status.out_free;
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            idx_reg   <= '0;
        end else begin
            case (state_reg)
                S_LOAD: begin
                    if (in_valid && in_last) begin
                        idx_reg   <= '0;
                        state_reg <= S_SEL;
                    end
                end
                S_SEL: begin
                    state_reg <= S_EVAL;
                end
                S_EVAL: begin
                    if (at_last) begin
                        idx_reg   <= '0;
                        state_reg <= S_EMIT;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SEL;
                    end
                end
                S_EMIT: begin
                    if (status.out_free) begin
                        if (at_last) state_reg <= S_SUM;
                        else         idx_reg   <= idx_reg + 1'b1;
                    end
                end
                S_SUM: begin
                    if (status.out_free) state_reg <= S_LOAD;
                end
                default: begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    // The walk index stays inside the loaded set
    `IGC_ASSERT_IMP(a_idx_in_set, cmd.sel || cmd.emit_item, CNT_W'(idx_reg) < status.count, "index beyond set")
    // A run never starts empty
    `IGC_ASSERT_IMP(a_run_nonempty, state_reg == S_EVAL, status.count != '0, "walk over empty set")
    // Word only written into a free output register
    `IGC_ASSERT(a_emit_free, $past(cmd.emit_item || cmd.emit_sum) |-> $past(status.out_free), "output overwritten")

endmodule

>>> rtl/interval_graph_coloring_top.sv
// Interval graph greedy colouring: collects intervals until one marked last, sorts them by
// begin, colours each greedily and sends the coloured intervals then one summary word.
// Each word is inserted by a shift of the cell row; the overlap walk then takes the intervals
// one at a time, selecting each and comparing it against every cell at once; then each
// coloured interval and the summary are sent. Input is refused from the last word until
// the summary has been loaded into the output register. Up to 32 intervals are stored;
// further ones are dropped and flagged in the summary.
// Depends on igc_pkg, igc_ctrl and igc_datapath.
module interval_graph_coloring_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  igc_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output igc_pkg::out_word_t m_data
);
    import igc_pkg::*;

    cmd_t    cmd;
    status_t status;

    igc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_last  (s_data.last_interval),
        .in_ready (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    igc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_word   (s_data),
        .out_word  (m_data),
        .out_valid (m_valid),
        .out_ready (m_ready)
    );

endmodule
